// ===== src/cqke_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqke_pkg
// Shared types and codes of the keyed circular queue: opcodes, status codes,
// the search token that moves along the slot chain and the slot write bundle.
// ----------------------------------------------------------------------------
package cqke_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_W         = 5;
  localparam int CAP_RESET     = 16;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // Search token. It collects the first matching entry and, on its way past
  // the head slot, a copy of the head entry.
  typedef struct packed {
    logic       live;
    logic [7:0] key;
    logic       hit;
    logic [7:0] fv;
    logic [7:0] fp;
    logic [7:0] hv;
    logic [7:0] hp;
    logic       hu;
  } cqke_tok_t;

  // Write controls broadcast to every slot cell.
  typedef struct packed {
    logic       wb_en;
    logic       ins_en;
    logic       clr;
    logic [7:0] ins_char;
    logic [7:0] ins_tag;
  } cqke_ctrl_t;

endpackage
`default_nettype wire

// ===== src/cqke_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqke_cell
// One queue slot. Holds a character, a priority tag and a used bit, and
// passes the search token on to the next slot once per cycle.
// ----------------------------------------------------------------------------
module cqke_cell import cqke_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cqke_ctrl_t               ctrl,
  input  logic [$clog2(DEPTH)-1:0] head_idx,
  input  logic [$clog2(DEPTH)-1:0] tail_idx,
  input  cqke_tok_t                wb_tok,
  input  cqke_tok_t                tok_in,
  output cqke_tok_t                tok_out,
  output logic                     used
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [7:0] slot_char;
  logic [7:0] slot_tag;
  logic       hit_here;
  logic       is_head;
  logic       is_tail;
  logic       first_hit;
  cqke_tok_t  tok_next;

  assign is_head   = (head_idx == MY_IDX);
  assign is_tail   = (tail_idx == MY_IDX);
  assign first_hit = used && (slot_tag == tok_in.key) && !tok_in.hit;

  always_comb begin
    tok_next = tok_in;
    if (first_hit) begin
      tok_next.hit = 1'b1;
      tok_next.fv  = slot_char;
      tok_next.fp  = slot_tag;
    end
    if (is_head) begin
      tok_next.hv = slot_char;
      tok_next.hp = slot_tag;
      tok_next.hu = used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= 1'b0;
      hit_here     <= 1'b0;
      tok_out.live <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.live) begin
        hit_here <= first_hit;
      end
      if (ctrl.clr) begin
        used <= 1'b0;
      end else if (ctrl.wb_en) begin
        // The head slot empties; the matched slot takes the head entry.
        if (is_head) begin
          used <= 1'b0;
        end else if (hit_here) begin
          used <= wb_tok.hu;
        end
      end else if (ctrl.ins_en && is_tail) begin
        used <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wb_en && hit_here && !is_head) begin
      slot_char <= wb_tok.hv;
      slot_tag  <= wb_tok.hp;
    end else if (ctrl.ins_en && is_tail) begin
      slot_char <= ctrl.ins_char;
      slot_tag  <= ctrl.ins_tag;
    end
  end

endmodule
`default_nettype wire

// ===== src/circular_queue_key_extract.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_queue_key_extract
// Circular queue of character slots with priority tags and extract-by-key.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel (in_valid / in_stall) carries one command per transfer:
// insert, extract by priority, or clear. Every command yields exactly one
// result transfer on the output channel (out_valid / out_stall) with a status
// code, the extracted character and priority, and the fill count afterwards.
// The capacity register is written through cfg_valid / cfg_ready; cfg_ready
// is always high. A written capacity waits until the next clear, which loads
// it into the ring (0 acts as 1, values above DEPTH act as DEPTH).
// Timing: one command is worked on at a time. Insert, clear, an extract on an
// empty queue and an unknown opcode load their result into the pending
// registers at the command transfer, then into the output register. An extract
// on a non-empty queue runs a search token down DEPTH slot cells, one per
// cycle; the slot write-back comes with the pending result at its end, then the
// output register loads. The next command is taken the cycle after a result
// loads. A result blocked by out_stall waits in a pending register with
// in_stall high until the output register frees.
// Reset empties the queue, sets head, tail and count to zero and the capacity
// to 16 (or DEPTH if smaller); slot contents are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_key_extract import cqke_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       opcode,
  input  logic [7:0]       item_value,
  input  logic [7:0]       item_priority,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic [7:0]       found_value,
  output logic [7:0]       found_priority,
  output logic [CAP_W-1:0] fill_count,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] capacity
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = ((IW > CAP_W) ? IW : CAP_W) + 1;
  localparam logic [CAP_W-1:0] CAP_RESET_ACT =
    (DEPTH < CAP_RESET) ? CAP_W'(DEPTH) : CAP_W'(CAP_RESET);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  state_t           state;
  logic [CAP_W-1:0] cap_pending;
  logic [CAP_W-1:0] cap_active;
  logic [CAP_W-1:0] cap_clamped;
  logic [IW-1:0]    head;
  logic [IW-1:0]    tail;
  logic [CAP_W-1:0] count;
  logic [IW-1:0]    head_next;
  logic [IW-1:0]    tail_next;
  logic [CMPW-1:0]  head_inc;
  logic [CMPW-1:0]  tail_inc;
  logic             full;
  logic             in_accept;
  logic             out_free;

  // Pending result, waiting for the output register.
  logic [2:0]       res_status;
  logic [7:0]       res_fv;
  logic [7:0]       res_fp;
  logic [CAP_W-1:0] res_fill;

  cqke_tok_t        scan_tok;
  cqke_tok_t        tok [0:DEPTH];
  cqke_tok_t        end_tok;
  cqke_ctrl_t       ctrl;
  logic [DEPTH-1:0] used_vec;
  logic [DEPTH:0]   live_vec;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign full      = (count >= cap_active);
  assign end_tok   = tok[DEPTH];

  // Ring pointers wrap at the active capacity.
  assign head_inc  = CMPW'(head) + CMPW'(1);
  assign tail_inc  = CMPW'(tail) + CMPW'(1);
  assign head_next = (head_inc == CMPW'(cap_active)) ? '0 : head_inc[IW-1:0];
  assign tail_next = (tail_inc == CMPW'(cap_active)) ? '0 : tail_inc[IW-1:0];

  always_comb begin
    if (cap_pending == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (int'(cap_pending) > DEPTH) begin
      cap_clamped = CAP_W'(DEPTH);
    end else begin
      cap_clamped = cap_pending;
    end
  end

  // Slot writes are decided in the same cycle as the command transfer
  // (insert, clear) or as the end of the search (write-back).
  always_comb begin
    ctrl          = '0;
    ctrl.ins_char = item_value;
    ctrl.ins_tag  = item_priority;
    if (in_accept && (opcode == OP_INSERT) && !full) begin
      ctrl.ins_en = 1'b1;
    end
    if (in_accept && (opcode == OP_CLEAR)) begin
      ctrl.clr = 1'b1;
    end
    if ((state == S_SCAN) && end_tok.live && end_tok.hit) begin
      ctrl.wb_en = 1'b1;
    end
  end

  // Chain of slot cells; the search token enters at slot 0.
  assign tok[0] = scan_tok;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cqke_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .head_idx (head),
      .tail_idx (tail),
      .wb_tok   (end_tok),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .used     (used_vec[i])
    );
  end

  for (genvar i = 0; i <= DEPTH; i++) begin : g_live
    assign live_vec[i] = tok[i].live;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cap_pending <= CAP_W'(CAP_RESET);
      cap_active  <= CAP_RESET_ACT;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
      scan_tok    <= '0;
    end else begin
      scan_tok.live <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cap_pending <= capacity;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            res_fv   <= '0;
            res_fp   <= '0;
            res_fill <= count;
            state    <= S_RESP;
            case (opcode)
              OP_INSERT: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  tail       <= tail_next;
                  count      <= count + CAP_W'(1);
                  res_fill   <= count + CAP_W'(1);
                  res_status <= ST_INSERTED;
                end
              end
              OP_EXTRACT: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  scan_tok.live <= 1'b1;
                  scan_tok.key  <= item_priority;
                  scan_tok.hit  <= 1'b0;
                  state         <= S_SCAN;
                end
              end
              OP_CLEAR: begin
                head       <= '0;
                tail       <= '0;
                count      <= '0;
                cap_active <= cap_clamped;
                res_fill   <= '0;
                res_status <= ST_CLEARED;
              end
              default: begin
                res_status <= ST_NOTFOUND;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (end_tok.live) begin
            state <= S_RESP;
            if (end_tok.hit) begin
              head       <= head_next;
              count      <= count - CAP_W'(1);
              res_fill   <= count - CAP_W'(1);
              res_status <= ST_FOUND;
              res_fv     <= end_tok.fv;
              res_fp     <= end_tok.fp;
            end else begin
              res_fill   <= count;
              res_status <= ST_NOTFOUND;
            end
          end
        end

        S_RESP: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            found_value    <= res_fv;
            found_priority <= res_fp;
            fill_count     <= res_fill;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never exceeds the ring size in use.
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= cap_active)
    else $error("fill count above active capacity");

  // Occupied slots and the fill count agree at all times.
  a_used_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(used_vec) == int'(count))
    else $error("used slots disagree with fill count");

  // At most one search token travels the chain.
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(live_vec))
    else $error("more than one search token in the chain");

  // A write-back happens only at the end of a search.
  a_wb_after_scan: assert property (@(posedge clk) disable iff (rst)
    ctrl.wb_en |=> (state == S_RESP))
    else $error("slot write-back outside a search");

endmodule
`default_nettype wire
